/* rtl/strhash_pkg.sv */
// Shared types and constants for the universal string hash block.
`default_nettype none
package strhash_pkg;

    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [31:0] MULT_START   = 32'd31415;
    localparam logic [14:0] MULT_STEP    = 15'd27183;
    localparam logic [31:0] TABLE_RESET  = 32'd1024;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic can_commit;
    } t_sts;

endpackage
`default_nettype wire

/* rtl/strhash_if.sv */
// Channel interfaces for key bytes and finished hash values.
`default_nettype none
interface strhash_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface strhash_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink (input valid, input hash_value, output ready);
endinterface
`default_nettype wire

/* rtl/strhash_ctrl.sv */
// Controller state machine that sequences multiply, divide and update for each byte.
`default_nettype none
module strhash_ctrl
    import strhash_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               last_step;

    assign last_step = (r_count == CNT_W'(DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (last_step) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (i_sts.can_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        n_count    = r_count;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_count   = '0;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                n_count    = r_count + 1'b1;
            end
            ST_UPD: begin
                o_cmd.commit = i_sts.can_commit;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

/* rtl/strhash_dp.sv */
// Datapath with running hash and multiplier, two products, two remainder units and output register.
`default_nettype none
module strhash_dp
    import strhash_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [31:0] i_table_size,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [31:0]      o_hash_value
);

    logic [31:0] r_hash;
    logic [31:0] r_mult;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [63:0] r_dvd_h;
    logic [63:0] r_dvd_m;
    logic [31:0] r_rem_h;
    logic [31:0] r_rem_m;
    logic        r_out_valid;
    logic [31:0] r_out_hash;

    logic [63:0] prod_h;
    logic [46:0] prod_m;
    logic [31:0] div_m;
    logic [32:0] sh_h;
    logic [32:0] sh_m;
    logic [31:0] n_rem_h;
    logic [31:0] n_rem_m;
    logic        tiny;
    logic [31:0] new_hash;
    logic [31:0] new_mult;

    assign prod_h = ({32'b0, r_mult} * {32'b0, r_hash}) + {56'b0, r_byte};
    assign prod_m = {15'b0, r_mult} * {32'b0, MULT_STEP};
    assign div_m  = i_table_size - 32'd1;

    assign sh_h = {r_rem_h, r_dvd_h[63]};
    assign sh_m = {r_rem_m, r_dvd_m[63]};

    always_comb begin
        n_rem_h = sh_h[31:0];
        if (sh_h >= {1'b0, i_table_size}) begin
            n_rem_h = 32'(sh_h - {1'b0, i_table_size});
        end
        n_rem_m = sh_m[31:0];
        if (sh_m >= {1'b0, div_m}) begin
            n_rem_m = 32'(sh_m - {1'b0, div_m});
        end
    end

    assign tiny     = (i_table_size < 32'd2);
    assign new_hash = tiny ? 32'd0 : r_rem_h;
    assign new_mult = tiny ? r_mult : r_rem_m;

    assign o_sts.can_commit = !r_last || !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
        if (i_cmd.mul) begin
            r_dvd_h <= prod_h;
            r_dvd_m <= {17'b0, prod_m};
            r_rem_h <= '0;
            r_rem_m <= '0;
        end else if (i_cmd.step) begin
            r_dvd_h <= {r_dvd_h[62:0], 1'b0};
            r_dvd_m <= {r_dvd_m[62:0], 1'b0};
            r_rem_h <= n_rem_h;
            r_rem_m <= n_rem_m;
        end
        if (i_cmd.commit && r_last) begin
            r_out_hash <= new_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_mult      <= MULT_START;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                if (r_last) begin
                    r_hash <= '0;
                    r_mult <= MULT_START;
                end else begin
                    r_hash <= new_hash;
                    r_mult <= new_mult;
                end
            end
            if (i_cmd.commit && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out_hash;

endmodule
`default_nettype wire

/* rtl/string_universal_hash_mod_top.sv */
// Top level of the universal string hash: table size register, controller and datapath.
// Each byte goes through the accept and multiply states, the bit-serial steps of both remainder units
// and the update state before the next byte is taken; a last byte's update waits while a hash is untaken.
// The hash of a key is registered into the output register by the update of its last byte.
// The output register lets the next byte be taken while a finished hash waits to be taken.
// Synchronous active-low reset sets the table size to 1024, the hash to 0 and the multiplier to 31415.
`default_nettype none
module string_universal_hash_mod_top
    import strhash_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    strhash_byte_if.sink     i_byte,
    strhash_hash_if.source   o_hash,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data
);

    logic [31:0] r_table_size;
    t_cmd        cmd;
    t_sts        sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_RESET;
        end else if (i_cfg_wr_en) begin
            r_table_size <= i_cfg_wr_data;
        end
    end

    strhash_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_byte.valid),
        .o_in_ready (i_byte.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    strhash_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_table_size (r_table_size),
        .i_data_byte  (i_byte.data_byte),
        .i_last_byte  (i_byte.last_byte),
        .i_out_ready  (o_hash.ready),
        .o_out_valid  (o_hash.valid),
        .o_hash_value (o_hash.hash_value)
    );

    a_one_byte_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte.valid && i_byte.ready) |=> !i_byte.ready)
        else $error("A second byte was offered for transfer while one is in progress.");

    a_hash_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hash.valid && (r_table_size >= 32'd2)) |-> (o_hash.hash_value < r_table_size))
        else $error("The hash value is not below the table size.");

    a_hash_zero_small_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hash.valid && (r_table_size < 32'd2)) |-> (o_hash.hash_value == 32'd0))
        else $error("The hash value is not zero for a table of fewer than two buckets.");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_hash.valid) |-> $past(cmd.commit))
        else $error("A result appeared without an update of the last byte.");

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the universal string hash block, with its own bit-exact hash model.
`default_nettype none
module testbench
    import strhash_pkg::*;
;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_key_byte;

    localparam int unsigned GAP_MAX        = 14;
    localparam int unsigned DRAIN_CYCLES   = 80;
    localparam int unsigned HOLD_CYCLES    = 1500;
    localparam int unsigned BYTES_PER_SIZE = 170;
    localparam int unsigned MAX_REPORTS    = 10;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    strhash_byte_if byte_ch ();
    strhash_hash_if hash_ch ();

    logic        src_valid   = 1'b0;
    logic [7:0]  src_byte    = 8'd0;
    logic        src_last    = 1'b0;
    logic        snk_ready   = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = 32'd0;

    assign byte_ch.valid     = src_valid;
    assign byte_ch.data_byte = src_byte;
    assign byte_ch.last_byte = src_last;
    assign hash_ch.ready     = snk_ready;

    string_universal_hash_mod_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (byte_ch),
        .o_hash       (hash_ch),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    t_key_byte   key_bytes_pending[$];
    logic [31:0] hash_expected[$];

    logic [31:0] mdl_table = TABLE_RESET;
    logic [31:0] mdl_hash  = 32'd0;
    logic [31:0] mdl_mult  = MULT_START;

    int unsigned mismatches = 0;
    bit          quiet      = 1'b0;
    int unsigned src_gap    = 0;
    int unsigned snk_gap    = 0;
    int unsigned hold_left  = 0;
    bit          hold_req   = 1'b0;
    bit          hold_done  = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic hash_absorb_byte(input t_key_byte kb);
        bit [63:0] modulus;
        bit [63:0] prod;
        modulus = {32'd0, mdl_table};
        if (modulus < 64'd2) begin
            mdl_hash = 32'd0;
        end else begin
            prod     = {32'd0, mdl_mult} * {32'd0, mdl_hash} + {56'd0, kb.data_byte};
            mdl_hash = 32'(prod % modulus);
            mdl_mult = 32'(({32'd0, mdl_mult} * 64'(MULT_STEP)) % (modulus - 64'd1));
        end
        if (kb.last_byte) begin
            hash_expected.push_back(mdl_hash);
            mdl_hash = 32'd0;
            mdl_mult = MULT_START;
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (mismatches < MAX_REPORTS)
            $display("hash mismatch (%s): expected %0d, got %0d", what, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_key_byte   nxt;
        logic        offer;
        int unsigned gap;
        if (!i_rst_n) begin
            src_valid <= 1'b0;
            src_gap   <= 0;
        end else begin
            offer = src_valid;
            gap   = src_gap;
            if (src_valid && byte_ch.ready) begin
                hash_absorb_byte({src_byte, src_last});
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap != 0) begin
                    gap--;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    gap = $urandom_range(0, GAP_MAX - 1);
                end else if (key_bytes_pending.size() != 0) begin
                    nxt = key_bytes_pending.pop_front();
                    src_byte <= nxt.data_byte;
                    src_last <= nxt.last_byte;
                    offer = 1'b1;
                end
            end
            src_valid <= offer;
            src_gap   <= gap;
        end
    end

    always @(posedge i_clk) begin
        logic [31:0] want;
        logic        rdy;
        int unsigned gap;
        if (!i_rst_n) begin
            snk_ready <= 1'b0;
            snk_gap   <= 0;
        end else begin
            if (hash_ch.valid && snk_ready) begin
                if (hash_expected.size() == 0) begin
                    note_mismatch("unexpected transfer", 32'd0, hash_ch.hash_value);
                end else begin
                    want = hash_expected.pop_front();
                    if (hash_ch.hash_value !== want)
                        note_mismatch("hash_value", want, hash_ch.hash_value);
                end
            end
            gap = snk_gap;
            rdy = 1'b1;
            if (hold_left != 0) begin
                rdy = 1'b0;
            end else if (gap != 0) begin
                gap--;
                rdy = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(0, GAP_MAX - 1);
                rdy = 1'b0;
            end
            snk_ready <= rdy;
            snk_gap   <= gap;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        t_key_byte kb;
        kb.data_byte = b;
        kb.last_byte = last;
        key_bytes_pending.push_back(kb);
    endtask

    function automatic logic [7:0] random_key_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_random_bytes(input int unsigned count, input bit leave_open);
        int unsigned queued;
        int unsigned len;
        queued = 0;
        while (queued < count) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int unsigned k = 0; k < len; k++)
                push_byte(random_key_byte(), k == len - 1);
            queued += len;
        end
        if (leave_open) begin
            len = $urandom_range(1, 5);
            for (int unsigned k = 0; k < len; k++)
                push_byte(random_key_byte(), 1'b0);
        end
    endtask

    task automatic wait_idle();
        while (key_bytes_pending.size() != 0 || src_valid || hash_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_table_size(input logic [31:0] value);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        mdl_table = value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [31:0] sizes[$];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b1);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h63, 1'b1);
        wait_idle();

        sizes = '{32'd2, 32'hFFFF_FFFF, 32'd3, 32'd0, 32'd1, 32'hFFFF_FFFE, 32'h8000_0000,
                  32'($urandom_range(2, 1000)), $urandom, 32'd257, $urandom, TABLE_RESET};
        foreach (sizes[i]) begin
            write_table_size(sizes[i]);
            if (i == sizes.size() - 1)
                quiet = 1'b1;
            push_random_bytes(BYTES_PER_SIZE, i % 2 == 1 && i != sizes.size() - 1);
            if (i == 1) begin
                while (key_bytes_pending.size() > 120)
                    @(posedge i_clk);
                hold_req <= 1'b1;
            end
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
